### src/rotenc_pkg.sv
// rotenc_pkg: shared types and constants of the rotary encoder event queue
// transaction payload structs, action and register codes, lane control structs
// no dependencies
package rotenc_pkg;

    localparam int NUM_ENCODERS_DEF = 5;
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int PIN_LANES        = 5;
    localparam int INDEX_W          = 3;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 8;

    localparam logic [7:0] LOCKOUT_RESET       = 8'd60;
    localparam logic [2:0] ENCODER_COUNT_RESET = 3'd1;
    localparam logic       DIR_RIGHT           = 1'b1;
    localparam logic       DIR_LEFT            = 1'b0;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_POP    = 2'd2
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ENCODER_COUNT = 2'd0,
        REG_LOCKOUT_TICKS = 2'd1
    } reg_index_t;

    typedef struct packed {
        action_t              action;
        logic [PIN_LANES-1:0] pins_a;
        logic [PIN_LANES-1:0] pins_b;
        logic [INDEX_W-1:0]   encoder_index;
    } item_t;

    typedef struct packed {
        logic                 event_valid;
        logic                 direction;
        logic [PIN_LANES-1:0] available_mask;
        logic [PIN_LANES-1:0] dropped_mask;
    } result_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic dir;
    } lane_cmd_t;

    typedef struct packed {
        logic not_empty;
        logic dropped;
        logic popped;
    } lane_status_t;

endpackage

### src/rotenc_ram.sv
// rotenc_ram: generic single write port, single read port ram
// registered read data held between reads; no dependencies
module rotenc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/rotenc_lane.sv
// rotenc_lane: one encoder's event fifo with pointers and fill level
// uses rotenc_pkg lane structs and rotenc_ram for the event store
module rotenc_lane #(
    parameter int QUEUE_DEPTH = rotenc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rotenc_pkg::lane_cmd_t    cmd,
    output rotenc_pkg::lane_status_t status,
    output logic                    rd_dir
);

    localparam int AddrW = $clog2(QUEUE_DEPTH);
    localparam int FillW = $clog2(QUEUE_DEPTH + 1);

    logic [AddrW-1:0] wr_pos_reg, wr_pos_next;
    logic [AddrW-1:0] rd_pos_reg, rd_pos_next;
    logic [FillW-1:0] fill_reg, fill_next;
    logic             full, empty, do_push, do_pop;

    assign full    = (fill_reg == FillW'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = cmd.push && !full;
    assign do_pop  = cmd.pop && !empty;

    always_comb
    begin
        wr_pos_next = wr_pos_reg;
        rd_pos_next = rd_pos_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_pos_next = (wr_pos_reg == AddrW'(QUEUE_DEPTH - 1)) ? '0 : wr_pos_reg + 1'b1;
            fill_next   = fill_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_pos_next = (rd_pos_reg == AddrW'(QUEUE_DEPTH - 1)) ? '0 : rd_pos_reg + 1'b1;
            fill_next   = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg <= '0;
            rd_pos_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_pos_reg <= wr_pos_next;
            rd_pos_reg <= rd_pos_next;
            fill_reg   <= fill_next;
        end
    end

    assign status.not_empty = (fill_next != '0);
    assign status.dropped   = cmd.push && full;
    assign status.popped    = do_pop;

    rotenc_ram #(
        .WIDTH (1),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (do_push),
        .wr_addr (wr_pos_reg),
        .wr_data (cmd.dir),
        .rd_en   (do_pop),
        .rd_addr (rd_pos_reg),
        .rd_data (rd_dir)
    );

endmodule

### src/rotenc_merge.sv
// rotenc_merge: combines lane status into one result and holds the output register
// uses rotenc_pkg result and lane status types
module rotenc_merge #(
    parameter int LANES = rotenc_pkg::PIN_LANES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [rotenc_pkg::INDEX_W-1:0]      pop_lane,
    input  rotenc_pkg::lane_status_t [LANES-1:0] status,
    input  logic [LANES-1:0]                    rd_dir,
    output logic                                ready,
    output logic                                result_valid,
    input  logic                                result_stall,
    output rotenc_pkg::result_t                 result
);

    localparam int MaskW = rotenc_pkg::PIN_LANES;

    logic                               s1_valid_reg, s1_valid_next;
    logic                               s1_pop_reg;
    logic [rotenc_pkg::INDEX_W-1:0]     s1_lane_reg;
    logic [MaskW-1:0]                   s1_avail_reg, s1_drop_reg;
    logic                               out_valid_reg, out_valid_next;
    rotenc_pkg::result_t                out_reg;
    logic                               out_adv;
    logic [MaskW-1:0]                   avail, drop;
    logic                               popped, sel_dir;

    always_comb
    begin
        avail  = '0;
        drop   = '0;
        popped = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            avail[i] = status[i].not_empty;
            drop[i]  = status[i].dropped;
            popped   = popped | status[i].popped;
        end
    end

    always_comb
    begin
        sel_dir = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            if (s1_lane_reg == rotenc_pkg::INDEX_W'(i))
            begin
                sel_dir = rd_dir[i];
            end
        end
    end

    assign out_adv        = !out_valid_reg || !result_stall;
    assign ready          = !s1_valid_reg || out_adv;
    assign s1_valid_next  = accept || (s1_valid_reg && !out_adv);
    assign out_valid_next = (s1_valid_reg && out_adv) || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pop_reg   <= popped;
            s1_lane_reg  <= pop_lane;
            s1_avail_reg <= avail;
            s1_drop_reg  <= drop;
        end
        if (s1_valid_reg && out_adv)
        begin
            out_reg.event_valid    <= s1_pop_reg;
            out_reg.direction      <= s1_pop_reg ? sel_dir : rotenc_pkg::DIR_LEFT;
            out_reg.available_mask <= s1_avail_reg;
            out_reg.dropped_mask   <= s1_drop_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### src/rotary_encoder_event_queue.sv
// rotary_encoder_event_queue: top level of the rotary encoder event queue
// uses rotenc_pkg, rotenc_lane (with rotenc_ram) and rotenc_merge
//
// usage
// the item channel (item_valid, item_stall, item) carries time ticks, pin
// samples and pop requests; every item gives exactly one result transaction
// on the result channel (result_valid, result_stall, result)
// the cfg channel writes encoder_count (index 0) and lockout_ticks (index 1);
// cfg_ready is always high, other indexes are ignored
// a result passes the stage and result registers; one item is taken every cycle
// while item_stall is low, each lane updating its fifo pointers in the cycle of
// acceptance and the popped entry coming from the lane ram's registered read
// the result register and the stage before it hold two transactions; while
// the receiver stalls and both are full, item_stall is high
// reset empties every queue, sets the lockout counter to 60, the B line history
// to all ones, encoder_count to 1 and lockout_ticks to 60; no clearing pass
module rotary_encoder_event_queue #(
    parameter int NUM_ENCODERS = rotenc_pkg::NUM_ENCODERS_DEF,
    parameter int QUEUE_DEPTH  = rotenc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  rotenc_pkg::item_t                   item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output rotenc_pkg::result_t                 result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rotenc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rotenc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int Lanes = (NUM_ENCODERS < rotenc_pkg::PIN_LANES) ?
                           NUM_ENCODERS : rotenc_pkg::PIN_LANES;
    localparam int PinW  = rotenc_pkg::PIN_LANES;

    logic [2:0]      encoder_count_reg, encoder_count_next;
    logic [7:0]      lockout_ticks_reg, lockout_ticks_next;
    logic [7:0]      lockout_reg, lockout_next;
    logic [PinW-1:0] prev_b_reg, prev_b_next;
    logic [PinW-1:0] falls;
    logic [Lanes-1:0] edge_req;
    logic            accept, ready, is_sample, is_pop, hit;

    rotenc_pkg::lane_cmd_t    [Lanes-1:0] lane_cmd;
    rotenc_pkg::lane_status_t [Lanes-1:0] lane_status;
    logic                     [Lanes-1:0] lane_dir;

    assign cfg_ready  = 1'b1;
    assign item_stall = !ready;
    assign accept     = item_valid && ready;
    assign is_sample  = (item.action == rotenc_pkg::ACT_SAMPLE);
    assign is_pop     = (item.action == rotenc_pkg::ACT_POP);
    assign falls      = prev_b_reg & ~item.pins_b;

    always_comb
    begin
        encoder_count_next = encoder_count_reg;
        lockout_ticks_next = lockout_ticks_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                rotenc_pkg::REG_ENCODER_COUNT: encoder_count_next = cfg_data[2:0];
                rotenc_pkg::REG_LOCKOUT_TICKS: lockout_ticks_next = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < Lanes; i++)
        begin : g_lane
            assign edge_req[i] = accept && is_sample && (lockout_reg == '0) && falls[i] &&
                                 (encoder_count_reg > 3'(i));
            assign lane_cmd[i].push = edge_req[i];
            assign lane_cmd[i].dir  = item.pins_a[i] ? rotenc_pkg::DIR_RIGHT :
                                                       rotenc_pkg::DIR_LEFT;
            assign lane_cmd[i].pop  = accept && is_pop &&
                                      (item.encoder_index == rotenc_pkg::INDEX_W'(i)) &&
                                      (encoder_count_reg > 3'(i));

            rotenc_lane #(
                .QUEUE_DEPTH (QUEUE_DEPTH)
            ) u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .cmd    (lane_cmd[i]),
                .status (lane_status[i]),
                .rd_dir (lane_dir[i])
            );
        end
    endgenerate

    assign hit = |edge_req;

    always_comb
    begin
        lockout_next = lockout_reg;
        prev_b_next  = prev_b_reg;
        if (accept)
        begin
            case (item.action)
                rotenc_pkg::ACT_TICK:
                begin
                    if (lockout_reg != '0)
                    begin
                        lockout_next = lockout_reg - 1'b1;
                    end
                end
                rotenc_pkg::ACT_SAMPLE:
                begin
                    if (hit)
                    begin
                        lockout_next = lockout_ticks_reg;
                    end
                    prev_b_next = item.pins_b;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encoder_count_reg <= rotenc_pkg::ENCODER_COUNT_RESET;
            lockout_ticks_reg <= rotenc_pkg::LOCKOUT_RESET;
            lockout_reg       <= rotenc_pkg::LOCKOUT_RESET;
            prev_b_reg        <= '1;
        end
        else
        begin
            encoder_count_reg <= encoder_count_next;
            lockout_ticks_reg <= lockout_ticks_next;
            lockout_reg       <= lockout_next;
            prev_b_reg        <= prev_b_next;
        end
    end

    rotenc_merge #(
        .LANES (Lanes)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .pop_lane     (item.encoder_index),
        .status       (lane_status),
        .rd_dir       (lane_dir),
        .ready        (ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### src/rotenc_checker.sv
// rotenc_checker: port level assertions for rotary_encoder_event_queue
// uses rotenc_pkg types; bound to the top level below
module rotenc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_stall,
    input logic                result_valid,
    input logic                result_stall,
    input rotenc_pkg::result_t result
);

    // a stalled result transaction holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // direction is zero without a popped event
    a_dir_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.event_valid |-> !result.direction)
        else $error("direction set without event");

    // a lane that dropped an event is full, hence not empty
    a_drop_avail: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.dropped_mask != '0) |->
        ((result.available_mask & result.dropped_mask) == result.dropped_mask) &&
        !result.event_valid)
        else $error("dropped lane shown empty or with pop");

    // an item taken with an empty output has result_valid high once it has passed the stage and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && !result_valid |=> ##1 result_valid)
        else $error("result missing after accepted item");

endmodule

bind rotary_encoder_event_queue rotenc_checker u_rotenc_checker (.*);

### test/tb_top.sv
// tb_top: self-checking testbench of rotary_encoder_event_queue
// directed table then random turns, ticks and pops, checked against an in-file decoder model
// depends on rotenc_pkg and the rotary_encoder_event_queue top level
module tb_top;
    import rotenc_pkg::*;

    localparam int NUM_LANES = NUM_ENCODERS_DEF;
    localparam int FIFO_DEPTH = QUEUE_DEPTH_DEF;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [PIN_LANES-1:0] B_IDLE = '1;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 150;
    localparam int NUM_PHASES = 8;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    typedef struct {
        logic [1:0]           action;
        logic [PIN_LANES-1:0] pins_a;
        logic [PIN_LANES-1:0] pins_b;
        logic [INDEX_W-1:0]   index;
        int                   reps;
        bit                   toggle_b;
        bit                   typed;
        result_t              want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    item_t item;
    logic result_valid;
    logic result_stall;
    result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit typed_flag;
    result_t typed_result;

    // decoder model state
    logic [2:0] enc_count_now;
    logic [7:0] lockout_reload;
    logic [7:0] lockout_left;
    logic [PIN_LANES-1:0] last_b;
    logic lane_store [NUM_LANES][FIFO_DEPTH];
    int wr_pos [NUM_LANES];
    int rd_pos [NUM_LANES];
    int fill [NUM_LANES];

    result_t pending_results [$];
    stim_row_t directed_rows [$];
    item_t batch_q [$];

    int items_sent;
    int results_seen;
    int mismatch_count;
    int cycle_count;
    int burst_left;
    int holdoffs_wanted;
    int holdoffs_done;
    int holdoff_left;
    int mode_left;
    int stall_phase;
    stall_mode_t stall_mode;

    int enc_plan [NUM_PHASES] = '{3, 0, 7, 5, 1, 6, 2, 4};
    int lock_plan [NUM_PHASES] = '{2, 5, 1, 255, 0, 3, 9, 1};

    rotary_encoder_event_queue DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic result_t decode_expected(item_t it);
        result_t r;
        logic [PIN_LANES-1:0] falls;
        int lanes;
        int idx;
        bit hit;
        r = '0;
        hit = 1'b0;
        lanes = (enc_count_now > NUM_LANES) ? NUM_LANES : int'(enc_count_now);
        if (it.action == ACT_TICK)
        begin
            if (lockout_left != 0)
                lockout_left = lockout_left - 8'd1;
        end
        else if (it.action == ACT_SAMPLE)
        begin
            falls = last_b & ~it.pins_b;
            if (lockout_left == 0)
            begin
                for (int i = 0; i < lanes && i < PIN_LANES; i++)
                begin
                    if (falls[i])
                    begin
                        hit = 1'b1;
                        if (fill[i] >= FIFO_DEPTH)
                            r.dropped_mask[i] = 1'b1;
                        else
                        begin
                            lane_store[i][wr_pos[i]] = it.pins_a[i] ? DIR_RIGHT : DIR_LEFT;
                            wr_pos[i] = (wr_pos[i] + 1) % FIFO_DEPTH;
                            fill[i]++;
                        end
                    end
                end
                if (hit)
                    lockout_left = lockout_reload;
            end
            last_b = it.pins_b;
        end
        else if (it.action == ACT_POP)
        begin
            idx = int'(it.encoder_index);
            if (idx < lanes && fill[idx] != 0)
            begin
                r.event_valid = 1'b1;
                r.direction = lane_store[idx][rd_pos[idx]];
                rd_pos[idx] = (rd_pos[idx] + 1) % FIFO_DEPTH;
                fill[idx]--;
            end
        end
        for (int i = 0; i < NUM_LANES && i < PIN_LANES; i++)
            r.available_mask[i] = (fill[i] != 0);
        return r;
    endfunction

    // config, accepted items and result transactions, all sampled at the edge
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ENCODER_COUNT)
                    enc_count_now = cfg_data[2:0];
                else if (cfg_index == REG_LOCKOUT_TICKS)
                    lockout_reload = cfg_data;
            end
            if (item_valid && !item_stall)
            begin
                want = decode_expected(item);
                if (typed_flag)
                    want = typed_result;
                pending_results.push_back(want);
            end
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("result %h arrived with nothing pending", result);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.event_valid !== want.event_valid)
                    begin
                        $error("event_valid: expected %0d, got %0d",
                               want.event_valid, result.event_valid);
                        mismatch_count++;
                    end
                    if (result.direction !== want.direction)
                    begin
                        $error("direction: expected %0d, got %0d",
                               want.direction, result.direction);
                        mismatch_count++;
                    end
                    if (result.available_mask !== want.available_mask)
                    begin
                        $error("available_mask: expected %b, got %b",
                               want.available_mask, result.available_mask);
                        mismatch_count++;
                    end
                    if (result.dropped_mask !== want.dropped_mask)
                    begin
                        $error("dropped_mask: expected %b, got %b",
                               want.dropped_mask, result.dropped_mask);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // receiver: random stall modes plus long hold-offs on request
    always @(posedge clk)
    begin
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            result_stall <= 1'b1;
        end
        else if (holdoffs_done < holdoffs_wanted)
        begin
            holdoffs_done++;
            holdoff_left = HOLDOFF_CYCLES - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(3));
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            stall_phase++;
            case (stall_mode)
                STALL_NONE:  result_stall <= 1'b0;
                STALL_LIGHT: result_stall <= ($urandom_range(3) == 0);
                STALL_HEAVY: result_stall <= ($urandom_range(3) != 0);
                default:     result_stall <= ((stall_phase % 5) < 2);
            endcase
        end
    end

    task automatic send_item(item_t it, bit typed, result_t want);
        int gap;
        item <= it;
        typed_flag <= typed;
        typed_result <= want;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 30);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_row(logic [1:0] act, logic [PIN_LANES-1:0] a, logic [PIN_LANES-1:0] b,
                           logic [INDEX_W-1:0] idx, int reps, bit toggle, bit typed,
                           logic [11:0] want);
        stim_row_t r;
        r.action = act;
        r.pins_a = a;
        r.pins_b = b;
        r.index = idx;
        r.reps = reps;
        r.toggle_b = toggle;
        r.typed = typed;
        r.want = result_t'(want);
        directed_rows.push_back(r);
    endtask

    // one chunk of random stimulus, mostly clean turns, ticks and pops
    task automatic make_batch(int lanes, int reload);
        item_t it;
        logic [PIN_LANES-1:0] turn_mask;
        int pick;
        int n;
        pick = $urandom_range(99);
        it.pins_a = PIN_LANES'($urandom);
        it.pins_b = PIN_LANES'($urandom);
        it.encoder_index = INDEX_W'($urandom);
        if (pick < 25)
        begin
            it.action = ACT_TICK;
            n = ($urandom_range(5) == 0) ? reload + 1 : $urandom_range(1, 4);
            repeat (n) batch_q.push_back(it);
        end
        else if (pick < 55)
        begin
            turn_mask = PIN_LANES'($urandom);
            it.action = ACT_SAMPLE;
            it.pins_b = B_IDLE & ~turn_mask;
            batch_q.push_back(it);
            it.pins_a = PIN_LANES'($urandom);
            it.pins_b = B_IDLE;
            batch_q.push_back(it);
        end
        else if (pick < 85)
        begin
            it.action = ACT_POP;
            if (lanes > 0 && $urandom_range(3) != 0)
                it.encoder_index = INDEX_W'($urandom_range(lanes - 1));
            batch_q.push_back(it);
        end
        else if (pick < 93)
        begin
            it.action = ACT_SAMPLE;
            batch_q.push_back(it);
        end
        else
        begin
            it.action = action_t'($urandom_range(3));
            if ($urandom_range(1) == 0)
                it.action = action_t'(ACT_UNUSED);
            batch_q.push_back(it);
        end
    endtask

    initial
    begin
        item_t it;
        stim_row_t row;
        logic [CFG_DATA_W-1:0] data;
        int lanes;
        int start_count;

        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        typed_flag = 1'b0;
        typed_result = '0;
        items_sent = 0;
        results_seen = 0;
        mismatch_count = 0;
        cycle_count = 0;
        burst_left = 0;
        holdoffs_wanted = 0;
        holdoffs_done = 0;
        holdoff_left = 0;
        mode_left = 0;
        stall_phase = 0;
        stall_mode = STALL_NONE;

        enc_count_now = ENCODER_COUNT_RESET;
        lockout_reload = LOCKOUT_RESET;
        lockout_left = LOCKOUT_RESET;
        last_b = B_IDLE;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            wr_pos[i] = 0;
            rd_pos[i] = 0;
            fill[i] = 0;
        end

        // action, pins_a, pins_b, index, repeat, toggle B, typed, {valid, dir, avail, dropped}
        add_row(ACT_POP,    5'h00, 5'h1F, 3'd0, 1,  0, 1, {1'b0, 1'b0, 5'h00, 5'h00});
        add_row(ACT_SAMPLE, 5'h1F, 5'h00, 3'd0, 1,  0, 1, {1'b0, 1'b0, 5'h00, 5'h00});
        add_row(ACT_SAMPLE, 5'h00, 5'h1F, 3'd0, 1,  0, 1, {1'b0, 1'b0, 5'h00, 5'h00});
        add_row(ACT_TICK,   5'h00, 5'h1F, 3'd0, 60, 0, 1, {1'b0, 1'b0, 5'h00, 5'h00});
        add_row(ACT_SAMPLE, 5'h1F, 5'h00, 3'd0, 1,  0, 1, {1'b0, 1'b0, 5'h1F, 5'h00});
        add_row(ACT_SAMPLE, 5'h00, 5'h1F, 3'd0, 1,  0, 1, {1'b0, 1'b0, 5'h1F, 5'h00});
        add_row(ACT_SAMPLE, 5'h00, 5'h00, 3'd0, 1,  0, 1, {1'b0, 1'b0, 5'h1F, 5'h00});
        add_row(ACT_POP,    5'h00, 5'h00, 3'd0, 1,  0, 1, {1'b1, 1'b1, 5'h1F, 5'h00});
        add_row(ACT_POP,    5'h00, 5'h00, 3'd0, 1,  0, 1, {1'b1, 1'b0, 5'h1E, 5'h00});
        add_row(ACT_POP,    5'h00, 5'h00, 3'd0, 1,  0, 1, {1'b0, 1'b0, 5'h1E, 5'h00});
        add_row(ACT_POP,    5'h1F, 5'h1F, 3'd7, 1,  0, 1, {1'b0, 1'b0, 5'h1E, 5'h00});
        add_row(ACT_POP,    5'h00, 5'h00, 3'd5, 1,  0, 1, {1'b0, 1'b0, 5'h1E, 5'h00});
        add_row(ACT_UNUSED, 5'h1F, 5'h1F, 3'd7, 1,  0, 1, {1'b0, 1'b0, 5'h1E, 5'h00});
        add_row(ACT_SAMPLE, 5'h0A, 5'h00, 3'd0, 32, 1, 0, 12'h000);
        add_row(ACT_SAMPLE, 5'h00, 5'h1F, 3'd0, 1,  0, 1, {1'b0, 1'b0, 5'h1F, 5'h00});
        add_row(ACT_SAMPLE, 5'h15, 5'h00, 3'd0, 1,  0, 1, {1'b0, 1'b0, 5'h1F, 5'h1F});
        add_row(ACT_TICK,   5'h00, 5'h00, 3'd0, 1,  0, 1, {1'b0, 1'b0, 5'h1F, 5'h00});
        add_row(ACT_POP,    5'h00, 5'h00, 3'd4, 1,  0, 1, {1'b1, 1'b1, 5'h1F, 5'h00});
        add_row(ACT_POP,    5'h00, 5'h00, 3'd3, 4,  0, 0, 12'h000);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        cfg_write(REG_ENCODER_COUNT, 8'd5);
        cfg_write(REG_LOCKOUT_TICKS, 8'd0);
        cfg_valid <= 1'b0;

        foreach (directed_rows[n])
        begin
            row = directed_rows[n];
            for (int k = 0; k < row.reps; k++)
            begin
                it.action = action_t'(row.action);
                it.pins_a = row.pins_a;
                it.pins_b = (row.toggle_b && (k % 2 == 0)) ? B_IDLE : row.pins_b;
                it.encoder_index = row.index;
                send_item(it, row.typed, row.want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            if (p == 2)
                cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
            data = CFG_DATA_W'($urandom);
            data[2:0] = 3'(enc_plan[p]);
            cfg_write(REG_ENCODER_COUNT, data);
            cfg_write(REG_LOCKOUT_TICKS, CFG_DATA_W'(lock_plan[p]));
            cfg_valid <= 1'b0;
            lanes = (enc_plan[p] > NUM_LANES) ? NUM_LANES : enc_plan[p];
            if (p == 0 || p == 5)
                holdoffs_wanted++;
            start_count = items_sent;
            while (items_sent - start_count < PHASE_ITEMS)
            begin
                make_batch(lanes, lock_plan[p]);
                while (batch_q.size() != 0)
                    send_item(batch_q.pop_front(), 1'b0, '0);
            end
        end

        wait_drained();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
